// ===== sv/supf_pkg.sv =====
// Shared types and constants of the sort / unique pairs filter.
// No dependencies; used by every module of the block.
package supf_pkg;

    localparam logic [1:0] MODE_PAIR     = 2'd0;
    localparam logic [1:0] MODE_DISTINCT = 2'd1;
    localparam logic [1:0] MODE_THRESH   = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;  // unused code, behaves as pair mode

    // register word index, taken from paddr[2]
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_MINCNT = 1'b1;

    localparam int MODE_BITS   = 2;
    localparam int MINCNT_BITS = 7;
    localparam logic [MINCNT_BITS-1:0] MINCNT_RESET = 7'd2;

    typedef struct packed {
        logic insert;   // place the broadcast pair in order
        logic shift;    // move every entry one cell toward the head
    } t_cell_ctl;

    typedef struct packed {
        logic step;     // head entry is consumed this cycle
        logic finish;   // chain is empty, close the set
    } t_emit_ctl;

endpackage

// ===== sv/supf_cell.sv =====
// One cell of the sorted insertion chain: holds one (value, keyword) entry.
// Depends on supf_pkg.
module supf_cell #(
    parameter int VB = 32,
    parameter int KB = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  supf_pkg::t_cell_ctl i_ctl,
    input  logic [VB-1:0]       i_new_v,
    input  logic [KB-1:0]       i_new_k,
    input  logic                i_prev_valid,
    input  logic [VB-1:0]       i_prev_v,
    input  logic [KB-1:0]       i_prev_k,
    input  logic                i_prev_lt,
    input  logic                i_next_valid,
    input  logic [VB-1:0]       i_next_v,
    input  logic [KB-1:0]       i_next_k,
    output logic                o_valid,
    output logic [VB-1:0]       o_v,
    output logic [KB-1:0]       o_k,
    output logic                o_lt,
    output logic                o_eq
);

    logic          r_valid;
    logic [VB-1:0] r_v;
    logic [KB-1:0] r_k;
    logic          n_valid;
    logic [VB-1:0] n_v;
    logic [KB-1:0] n_k;

    assign o_lt = !r_valid || (i_new_v < r_v) || (i_new_v == r_v && i_new_k < r_k);
    assign o_eq = r_valid && i_new_v == r_v && i_new_k == r_k;

    always_comb begin
        n_valid = r_valid;
        n_v     = r_v;
        n_k     = r_k;
        if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_v     = i_next_v;
            n_k     = i_next_k;
        end else if (i_ctl.insert && o_lt) begin
            if (i_prev_lt) begin
                n_valid = i_prev_valid;
                n_v     = i_prev_v;
                n_k     = i_prev_k;
            end else begin
                n_valid = 1'b1;
                n_v     = i_new_v;
                n_k     = i_new_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_k <= n_k;
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_k     = r_k;

endmodule

// ===== sv/supf_emit.sv =====
// Result selection and output register: run detection on the chain head,
// one pending result held back to mark the final beat. Depends on supf_pkg.
module supf_emit #(
    parameter int VB = 32,
    parameter int KB = 16,
    parameter int CW = 7,
    parameter int DW = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  supf_pkg::t_emit_ctl              i_ctl,
    input  logic [VB-1:0]                    i_head_v,
    input  logic [KB-1:0]                    i_head_k,
    input  logic                             i_next_valid,
    input  logic [VB-1:0]                    i_next_v,
    input  logic [supf_pkg::MODE_BITS-1:0]   i_mode,
    input  logic [supf_pkg::MINCNT_BITS-1:0] i_min_count,
    input  logic                             i_ovf,
    input  logic                             i_m_tready,
    output logic                             o_free,
    output logic                             o_m_tvalid,
    output logic [DW-1:0]                    o_m_tdata,  // value, keyword
    output logic                             o_m_tlast,
    output logic [1:0]                       o_m_tuser   // is_empty, overflowed
);

    logic          r_pend;
    logic [VB-1:0] r_pend_v;
    logic [KB-1:0] r_pend_k;
    logic [CW-1:0] r_run;
    logic          r_ovalid;
    logic [VB-1:0] r_out_v;
    logic [KB-1:0] r_out_k;
    logic          r_out_last;
    logic          r_out_empty;
    logic          r_out_ovf;

    logic          end_run;
    logic [CW-1:0] run;
    logic          qual;
    logic          load_out;

    assign end_run = !i_next_valid || (i_next_v != i_head_v);
    assign run     = r_run + CW'(1);

    always_comb begin
        case (i_mode)
            supf_pkg::MODE_DISTINCT: qual = end_run;
            supf_pkg::MODE_THRESH:   qual = end_run && (int'(run) >= int'(i_min_count));
            default:                 qual = 1'b1;
        endcase
    end

    assign o_free   = !r_ovalid || i_m_tready;
    assign load_out = (i_ctl.step && qual && r_pend) || i_ctl.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.step) begin
                r_run <= end_run ? '0 : run;
                if (qual) begin
                    r_pend <= 1'b1;
                end
            end else if (i_ctl.finish) begin
                r_pend <= 1'b0;
                r_run  <= '0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && qual) begin
            r_pend_v <= i_head_v;
            r_pend_k <= (i_mode == supf_pkg::MODE_PAIR || i_mode == supf_pkg::MODE_SPARE)
                        ? i_head_k : '0;
        end
        if (load_out) begin
            r_out_ovf  <= i_ovf;
            r_out_last <= i_ctl.finish;
            if (i_ctl.finish && !r_pend) begin
                r_out_v     <= '0;
                r_out_k     <= '0;
                r_out_empty <= 1'b1;
            end else begin
                r_out_v     <= r_pend_v;
                r_out_k     <= r_pend_k;
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = DW'({r_out_k, r_out_v});
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_empty};

endmodule

// ===== sv/sort_unique_pairs_filter_unit.sv =====
// Top level of the sort / unique pairs filter: APB registers, load and drain
// control, the chain of sorting cells and the result stage.
// Depends on supf_pkg, supf_cell and supf_emit.
//
// Usage: pairs arrive on the s_ stream, tdata = {keyword, value}, tlast closes
// a set. Each accepted pair is broadcast to a chain of MAX_ENTRIES cells that
// insert it in sorted order and drop an identical pair. Beats past
// MAX_ENTRIES in a set are dropped and flag overflowed. After the tlast beat
// s_tready falls and the chain shifts its entries out toward the head, one
// cell per cycle while the output register can take a result. Results leave
// on the m_ stream, tdata = {keyword, value}, tuser = {overflowed, is_empty},
// tlast on the final result; a set with no qualifying entry gives one beat
// with is_empty and tlast. When m_tready is low and the output register holds
// a result, the chain and run counter freeze and no result is lost. Reset
// empties the chain, clears the counters and sets output_mode to 0 and
// min_count to 2. The user must write registers through the APB port only
// while the block is idle; the block itself does not enforce this.
module sort_unique_pairs_filter_unit #(
    parameter int MAX_ENTRIES  = 64,
    parameter int VALUE_BITS   = 32,
    parameter int KEYWORD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [((VALUE_BITS+KEYWORD_BITS+7)/8)*8-1:0] s_tdata, // value, keyword
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((VALUE_BITS+KEYWORD_BITS+7)/8)*8-1:0] m_tdata, // value, keyword
    output logic                m_tlast,
    output logic [1:0]          m_tuser,  // is_empty, overflowed
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int VB = VALUE_BITS;
    localparam int KB = KEYWORD_BITS;
    localparam int DW = ((VB + KB + 7) / 8) * 8;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic {ST_LOAD, ST_DRAIN} t_state;

    t_state                             r_state;
    logic [CW-1:0]                      r_count;
    logic                               r_ovf;
    logic [supf_pkg::MODE_BITS-1:0]     r_mode;
    logic [supf_pkg::MINCNT_BITS-1:0]   r_min_count;

    logic [VB-1:0] new_v;
    logic [KB-1:0] new_k;
    logic          accept;
    logic          store;
    logic          dup;
    logic          out_free;
    logic          cfg_wr;

    supf_pkg::t_cell_ctl cell_ctl;
    supf_pkg::t_emit_ctl emit_ctl;

    logic          c_valid [MAX_ENTRIES];
    logic [VB-1:0] c_v     [MAX_ENTRIES];
    logic [KB-1:0] c_k     [MAX_ENTRIES];
    logic          c_lt    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] c_eq;

    assign new_v    = s_tdata[VB-1:0];
    assign new_k    = s_tdata[VB+KB-1:VB];
    assign s_tready = (r_state == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign store    = accept && (r_count < CW'(MAX_ENTRIES));
    assign dup      = |c_eq;

    assign cell_ctl.insert = store && !dup;
    assign cell_ctl.shift  = emit_ctl.step;
    assign emit_ctl.step   = (r_state == ST_DRAIN) && c_valid[0] && out_free;
    assign emit_ctl.finish = (r_state == ST_DRAIN) && !c_valid[0] && out_free;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            logic          prev_valid;
            logic [VB-1:0] prev_v;
            logic [KB-1:0] prev_k;
            logic          prev_lt;
            logic          next_valid;
            logic [VB-1:0] next_v;
            logic [KB-1:0] next_k;

            if (gi == 0) begin : g_head
                assign prev_valid = 1'b0;
                assign prev_v     = '0;
                assign prev_k     = '0;
                assign prev_lt    = 1'b0;
            end else begin : g_body
                assign prev_valid = c_valid[gi-1];
                assign prev_v     = c_v[gi-1];
                assign prev_k     = c_k[gi-1];
                assign prev_lt    = c_lt[gi-1];
            end

            if (gi == MAX_ENTRIES - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_v     = '0;
                assign next_k     = '0;
            end else begin : g_mid
                assign next_valid = c_valid[gi+1];
                assign next_v     = c_v[gi+1];
                assign next_k     = c_k[gi+1];
            end

            supf_cell #(
                .VB(VB),
                .KB(KB)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl),
                .i_new_v     (new_v),
                .i_new_k     (new_k),
                .i_prev_valid(prev_valid),
                .i_prev_v    (prev_v),
                .i_prev_k    (prev_k),
                .i_prev_lt   (prev_lt),
                .i_next_valid(next_valid),
                .i_next_v    (next_v),
                .i_next_k    (next_k),
                .o_valid     (c_valid[gi]),
                .o_v         (c_v[gi]),
                .o_k         (c_k[gi]),
                .o_lt        (c_lt[gi]),
                .o_eq        (c_eq[gi])
            );
        end
    endgenerate

    supf_emit #(
        .VB(VB),
        .KB(KB),
        .CW(CW),
        .DW(DW)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (emit_ctl),
        .i_head_v    (c_v[0]),
        .i_head_k    (c_k[0]),
        .i_next_valid(c_valid[1]),
        .i_next_v    (c_v[1]),
        .i_mode      (r_mode),
        .i_min_count (r_min_count),
        .i_ovf       (r_ovf),
        .i_m_tready  (m_tready),
        .o_free      (out_free),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            supf_pkg::REG_MODE:   prdata = 32'(r_mode);
            supf_pkg::REG_MINCNT: prdata = 32'(r_min_count);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= supf_pkg::MODE_PAIR;
            r_min_count <= supf_pkg::MINCNT_RESET;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    supf_pkg::REG_MODE:   r_mode      <= pwdata[supf_pkg::MODE_BITS-1:0];
                    supf_pkg::REG_MINCNT: r_min_count <= pwdata[supf_pkg::MINCNT_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (store) begin
                        r_count <= r_count + CW'(1);
                    end else if (accept) begin
                        r_ovf <= 1'b1;
                    end
                    if (accept && s_tlast) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (emit_ctl.finish) begin
                        r_state <= ST_LOAD;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[1] |-> c_valid[0])
        else $error("chain has a hole at the head");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty result not marked last");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.finish |=> r_count == '0 && !r_ovf && r_state == ST_LOAD && m_tvalid && m_tlast)
        else $error("set not closed after drain");

endmodule

// ===== tb/sv/sort_unique_pairs_filter_unit_test.sv =====
// Self-checking bench for sort_unique_pairs_filter_unit: random and directed pair sets,
// in every output mode, checked beat by beat against an in-bench sort/filter predictor.
// Depends on supf_pkg and sort_unique_pairs_filter_unit.
`timescale 1ns / 100ps

module sort_unique_pairs_filter_unit_test;

    localparam int          DEPTH       = 64;
    localparam int          STALL_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] keyword;
        logic        last;
    } t_pair;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] keyword;
        logic        is_empty;
        logic        overflowed;
        logic        last;
    } t_sort_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // [31:0] value, [47:32] keyword
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [31:0] value, [47:32] keyword
    logic        m_tlast;
    logic [1:0]  m_tuser;        // [0] is_empty, [1] overflowed
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    sort_unique_pairs_filter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stimulus and scoreboard state
    t_pair        pair_feed[$];
    t_sort_result results_due[$];
    int           n_sent      = 0;
    int           n_taken     = 0;
    int           mismatches  = 0;
    int           quiet_cycles = 0;
    logic         hold_rx     = 1'b0;

    // predictor state
    logic [31:0]  held_value[DEPTH];
    logic [15:0]  held_keyword[DEPTH];
    int           held_count    = 0;
    bit           held_overflow = 0;
    logic [1:0]   mode_reg      = supf_pkg::MODE_PAIR;
    logic [6:0]   min_reg       = supf_pkg::MINCNT_RESET;

    function automatic void absorb_pair(t_pair p);
        logic [31:0] sv[DEPTH];
        logic [15:0] sk[DEPTH];
        logic [31:0] ov[DEPTH];
        logic [15:0] ok[DEPTH];
        int n, j, m, run, k;
        t_sort_result r;
        n = 0;
        k = 0;
        if (held_count < DEPTH) begin
            held_value[held_count]   = p.value;
            held_keyword[held_count] = p.keyword;
            held_count++;
        end else begin
            held_overflow = 1;
        end
        if (!p.last) return;

        // sorted insertion, identical pairs kept once
        for (int i = 0; i < held_count; i++) begin
            j = 0;
            while (j < n && (sv[j] < held_value[i] ||
                   (sv[j] == held_value[i] && sk[j] < held_keyword[i])))
                j++;
            if (!(j < n && sv[j] == held_value[i] && sk[j] == held_keyword[i])) begin
                for (m = n; m > j; m--) begin
                    sv[m] = sv[m-1];
                    sk[m] = sk[m-1];
                end
                sv[j] = held_value[i];
                sk[j] = held_keyword[i];
                n++;
            end
        end

        case (mode_reg)
            supf_pkg::MODE_DISTINCT: begin
                for (int i = 0; i < n; i++)
                    if (i == 0 || sv[i] != sv[i-1]) begin
                        ov[k] = sv[i];
                        ok[k] = '0;
                        k++;
                    end
            end
            supf_pkg::MODE_THRESH: begin
                run = 1;
                for (int i = 1; i <= n; i++) begin
                    if (i == n || sv[i] != sv[i-1]) begin
                        if (run >= int'(min_reg)) begin
                            ov[k] = sv[i-1];
                            ok[k] = '0;
                            k++;
                        end
                        run = 1;
                    end else begin
                        run++;
                    end
                end
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    ov[k] = sv[i];
                    ok[k] = sk[i];
                    k++;
                end
            end
        endcase

        if (k == 0) begin
            r = '{value: '0, keyword: '0, is_empty: 1'b1, overflowed: held_overflow,
                  last: 1'b1};
            results_due.push_back(r);
        end else begin
            for (int i = 0; i < k; i++) begin
                r = '{value: ov[i], keyword: ok[i], is_empty: 1'b0,
                      overflowed: held_overflow, last: (i == k - 1)};
                results_due.push_back(r);
            end
        end
        held_count    = 0;
        held_overflow = 0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender: bursts of random length with random gaps
    t_pair on_bus;
    int    burst_left = 0;
    int    gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_pair(on_bus);
                n_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pair_feed.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = pair_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.keyword, on_bus.value};
                    s_tlast  <= on_bus.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: checks each result beat, stalls on its own pattern
    t_sort_result want;
    int           rx_tick  = 0;
    int           rx_style = 0;
    logic         rx_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result beat with none expected, got value %h keyword %h",
                             $time, m_tdata[31:0], m_tdata[47:32]);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("value", want.value, m_tdata[31:0]);
                    check_field("keyword", 32'(want.keyword), 32'(m_tdata[47:32]));
                    check_field("is_empty", 32'(want.is_empty), 32'(m_tuser[0]));
                    check_field("overflowed", 32'(want.overflowed), 32'(m_tuser[1]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            rx_tick++;
            if (rx_tick % 50 == 0) rx_style = $urandom_range(0, 3);
            case (rx_style)
                0:       rx_ready = 1'b1;
                1:       rx_ready = ($urandom_range(0, 1) == 1);
                2:       rx_ready = (rx_tick % 4 != 0);
                default: rx_ready = (rx_tick % 7 < 2);
            endcase
            m_tready <= rx_ready && !hold_rx;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        while (n_taken < 200 || pair_feed.size() < 8) @(posedge i_clk);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL sort_unique_pairs_filter_unit");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == supf_pkg::REG_MODE)
            mode_reg = data[1:0];
        else
            min_reg = data[6:0];
        @(posedge i_clk);
        check_field("pready", 32'(1'b1), 32'(pready));
        check_field("prdata", (idx == supf_pkg::REG_MODE) ? 32'(data[1:0]) : 32'(data[6:0]),
                    prdata);
    endtask

    task automatic wait_drained(input int settle);
        while (n_taken != n_sent || results_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic void queue_pair(logic [31:0] v, logic [15:0] k, logic last);
        pair_feed.push_back('{value: v, keyword: k, last: last});
        n_sent++;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom_range(0, 7);
            3:       return $urandom();
            4:       return 32'hFFFF_FFFF;
            default: return 32'h8000_0000 | $urandom_range(0, 1);
        endcase
    endfunction

    function automatic logic [15:0] rand_keyword();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom_range(0, 3));
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    // one_value: a single value carrying distinct keywords
    function automatic void queue_set(int size, bit one_value);
        logic [31:0] v;
        logic [15:0] base;
        v    = rand_value();
        base = 16'($urandom_range(0, 65535));
        for (int i = 0; i < size; i++) begin
            if (one_value)
                queue_pair(v, base + 16'(i), i == size - 1);
            else
                queue_pair(rand_value(), rand_keyword(), i == size - 1);
        end
    endfunction

    int         phase;
    logic [1:0] ph_mode;
    logic [6:0] ph_min;
    int         set_size;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pair mode at reset settings: field extremes and a repeated pair
        queue_pair(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_pair(32'h0000_0000, 16'h0000, 1'b0);
        queue_pair(32'h0000_0000, 16'hFFFF, 1'b0);
        queue_pair(32'hFFFF_FFFF, 16'h0000, 1'b0);
        queue_pair(32'h0000_0000, 16'h0000, 1'b0);
        queue_pair(32'h1234_5678, 16'hABCD, 1'b1);
        queue_pair(32'h5555_AAAA, 16'h5A5A, 1'b1);
        wait_drained(10);

        write_reg(supf_pkg::REG_MODE, 32'(supf_pkg::MODE_DISTINCT));
        queue_pair(32'd5, 16'd1, 1'b0);
        queue_pair(32'd5, 16'd2, 1'b0);
        queue_pair(32'd3, 16'd7, 1'b0);
        queue_pair(32'd5, 16'd1, 1'b1);
        wait_drained(10);

        write_reg(supf_pkg::REG_MODE, 32'(supf_pkg::MODE_THRESH));
        queue_pair(32'd9, 16'd1, 1'b0);
        queue_pair(32'd9, 16'd2, 1'b0);
        queue_pair(32'd9, 16'd1, 1'b0);
        queue_pair(32'd4, 16'd4, 1'b1);
        wait_drained(10);

        // threshold above the store size: empty result
        write_reg(supf_pkg::REG_MINCNT, 32'd65);
        queue_pair(32'd1, 16'd1, 1'b1);
        wait_drained(10);

        write_reg(supf_pkg::REG_MINCNT, 32'd0);
        queue_pair(32'd7, 16'd3, 1'b0);
        queue_pair(32'd2, 16'd2, 1'b1);
        wait_drained(10);

        write_reg(supf_pkg::REG_MODE, 32'(supf_pkg::MODE_SPARE));
        queue_pair(32'hAAAA_5555, 16'h5555, 1'b0);
        queue_pair(32'h5555_0000, 16'hAAAA, 1'b1);
        wait_drained(10);

        phase = 0;
        while (n_sent < 400) begin
            case (phase)
                0:       begin ph_mode = supf_pkg::MODE_PAIR;     ph_min = 7'd1;   end
                1:       begin ph_mode = supf_pkg::MODE_DISTINCT; ph_min = 7'd64;  end
                2:       begin ph_mode = supf_pkg::MODE_THRESH;   ph_min = 7'd1;   end
                3:       begin ph_mode = supf_pkg::MODE_THRESH;   ph_min = 7'd64;  end
                4:       begin ph_mode = supf_pkg::MODE_THRESH;   ph_min = 7'd127; end
                5:       begin ph_mode = supf_pkg::MODE_THRESH;   ph_min = 7'd2;   end
                6:       begin ph_mode = supf_pkg::MODE_SPARE;    ph_min = 7'd3;   end
                default: begin
                    ph_mode = 2'($urandom_range(0, 3));
                    ph_min  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(1, 4));
                end
            endcase
            write_reg(supf_pkg::REG_MODE, 32'(ph_mode));
            write_reg(supf_pkg::REG_MINCNT, 32'(ph_min));
            if (phase == 1) queue_set(65, 1'b0);
            if (phase == 3) queue_set(68, 1'b1);
            for (int s = 0; s < 4; s++) begin
                set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                       : $urandom_range(1, 10);
                queue_set(set_size, $urandom_range(0, 2) == 0);
            end
            wait_drained(10);
            phase++;
        end

        wait_drained(20);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS sort_unique_pairs_filter_unit");
        else
            $display("FAIL sort_unique_pairs_filter_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/supf_pkg.sv
sv/supf_cell.sv
sv/supf_emit.sv
sv/sort_unique_pairs_filter_unit.sv
tb/sv/sort_unique_pairs_filter_unit_test.sv
